### sv/slpb_pkg.sv
package slpb_pkg;

  // Stored base mode codes.
  typedef enum logic [1:0] {
    MODE_BOOT   = 2'd0,
    MODE_READY  = 2'd1,
    MODE_DRIVE  = 2'd2,
    MODE_PAUSED = 2'd3
  } mode_t;

  // Color source picked by the priority logic.
  typedef enum logic [2:0] {
    KIND_BASE   = 3'd0,
    KIND_STOP   = 3'd1,
    KIND_FAULT  = 3'd2,
    KIND_REMOTE = 3'd3,
    KIND_CMD    = 3'd4,
    KIND_LOCAL  = 3'd5,
    KIND_HEART  = 3'd6
  } kind_t;

  // One input word, unpacked from the stream data.
  typedef struct packed {
    logic [31:0] now_ms;
    logic        enabled;
    logic        set_base;
    logic [1:0]  base_mode;
    logic        raise_error;
    logic        stop_active;
    logic        remote_alarm;
    logic        local_alarm;
    logic        heartbeat_pulse;
    logic        command_pulse;
  } in_item_t;

  // Color triple; red sits in the lowest byte.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // Priority stage result.
  typedef struct packed {
    logic [31:0] now_ms;
    kind_t       kind;
    mode_t       mode;
  } s1_t;

  // Divider stage: blink phases and the coarse quotient of now / 1200.
  typedef struct packed {
    kind_t       kind;
    mode_t       mode;
    logic        odd200;
    logic        odd120;
    logic        odd300;
    logic [10:0] now_lo;
    logic [21:0] q1200;
  } s2_t;

  // Triangle stage: phase folded into the rising half, 0 to 600.
  typedef struct packed {
    kind_t      kind;
    mode_t      mode;
    logic       odd200;
    logic       odd120;
    logic       odd300;
    logic [9:0] ramp;
  } s3_t;

  // Window lengths in milliseconds.
  localparam logic [31:0] WIN_COMMAND = 32'd250;
  localparam logic [31:0] WIN_HEART   = 32'd200;

  // Breathing period and its half.
  localparam logic [10:0] BOOT_PERIOD = 11'd1200;
  localparam logic [10:0] BOOT_HALF   = 11'd600;

  // Reciprocals for exact division by constants.
  // now / 200 = (now >> 3) / 25, 29-bit dividend, shift 34.
  localparam logic [29:0] DIV25_M   = 30'(((64'd1 << 34) + 64'd24) / 64'd25);
  // now / 120 = (now >> 3) / 15, 29-bit dividend, shift 33.
  localparam logic [29:0] DIV15_M   = 30'(((64'd1 << 33) + 64'd14) / 64'd15);
  // now / 300 = (now >> 2) / 75, 30-bit dividend, shift 37.
  localparam logic [30:0] DIV300_M  = 31'(((64'd1 << 37) + 64'd74) / 64'd75);
  // now / 1200 = (now >> 4) / 75, 28-bit dividend, shift 35.
  localparam logic [28:0] DIV1200_M = 29'(((64'd1 << 35) + 64'd74) / 64'd75);
  // floor(t * 17 / 40) = (t * 17 * ceil(2^20 / 40)) >> 20 for t up to 600.
  localparam logic [18:0] BREATH_K  = 19'(64'd17 * (((64'd1 << 20) + 64'd39) / 64'd40));

  // Fixed colors.
  localparam rgb_t RGB_BLACK  = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
  localparam rgb_t RGB_RED    = '{blue: 8'd0,   green: 8'd0,   red: 8'd255};
  localparam rgb_t RGB_AMBER  = '{blue: 8'd0,   green: 8'd140, red: 8'd255};
  localparam rgb_t RGB_GREEN  = '{blue: 8'd0,   green: 8'd255, red: 8'd0};
  localparam rgb_t RGB_BLUE   = '{blue: 8'd255, green: 8'd0,   red: 8'd0};
  localparam rgb_t RGB_YELLOW = '{blue: 8'd0,   green: 8'd200, red: 8'd255};
  localparam rgb_t RGB_READY  = '{blue: 8'd255, green: 8'd255, red: 8'd255};
  localparam rgb_t RGB_DRIVE  = '{blue: 8'd200, green: 8'd200, red: 8'd200};
  localparam rgb_t RGB_PAUSED = '{blue: 8'd128, green: 8'd128, red: 8'd0};

endpackage

### sv/slpb_state.sv
module slpb_state (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  slpb_pkg::in_item_t item,
  output logic              ready_up,
  output logic              s1_valid,
  output slpb_pkg::s1_t     s1,
  input  logic              ready_dn
);

  slpb_pkg::mode_t mode_r, mode_nxt;
  logic            fault_r, fault_nxt;
  logic [31:0]     hb_r, hb_nxt;
  logic [31:0]     cmd_r, cmd_nxt;
  logic            v_r;
  slpb_pkg::s1_t   s1_r;

  logic            in_fire;
  logic [31:0]     hb_s, cmd_s;
  logic [31:0]     cmd_age, hb_age;
  logic            cmd_run, hb_run;
  slpb_pkg::kind_t kind;

  assign ready_up = !v_r || ready_dn;
  assign in_fire  = in_valid && ready_up;
  assign s1_valid = v_r;
  assign s1       = s1_r;

  // Strobes first, then the color priority with its stamp clearing.
  always_comb begin
    mode_nxt  = mode_r;
    fault_nxt = fault_r;
    if (item.set_base) begin
      mode_nxt = slpb_pkg::mode_t'(item.base_mode);
      if (item.base_mode == slpb_pkg::MODE_BOOT || item.base_mode == slpb_pkg::MODE_READY)
        fault_nxt = 1'b0;
    end
    if (item.raise_error)
      fault_nxt = 1'b1;
    hb_s  = item.heartbeat_pulse ? item.now_ms : hb_r;
    cmd_s = item.command_pulse ? item.now_ms : cmd_r;

    cmd_age = item.now_ms - cmd_s;
    hb_age  = item.now_ms - hb_s;
    cmd_run = (cmd_s != 32'd0) && (cmd_age < slpb_pkg::WIN_COMMAND);
    hb_run  = (hb_s != 32'd0) && (hb_age < slpb_pkg::WIN_HEART);

    hb_nxt  = hb_s;
    cmd_nxt = cmd_s;
    kind    = slpb_pkg::KIND_BASE;
    if (item.stop_active) begin
      kind = slpb_pkg::KIND_STOP;
    end else if (fault_nxt) begin
      kind = slpb_pkg::KIND_FAULT;
    end else if (item.remote_alarm) begin
      kind = slpb_pkg::KIND_REMOTE;
    end else if (cmd_run) begin
      kind = slpb_pkg::KIND_CMD;
    end else if (cmd_s != 32'd0) begin
      // Command window just ran out: base color and, on an enabled tick, clear the stamp.
      kind = slpb_pkg::KIND_BASE;
      if (item.enabled)
        cmd_nxt = 32'd0;
    end else if (item.local_alarm) begin
      kind = slpb_pkg::KIND_LOCAL;
    end else if (hb_run) begin
      kind = (mode_nxt == slpb_pkg::MODE_DRIVE) ? slpb_pkg::KIND_HEART : slpb_pkg::KIND_BASE;
    end else begin
      kind = slpb_pkg::KIND_BASE;
      if (item.enabled)
        hb_nxt = 32'd0;
    end
  end

  // Persistent state and the stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= slpb_pkg::MODE_BOOT;
      fault_r <= 1'b0;
      hb_r    <= 32'd0;
      cmd_r   <= 32'd0;
      v_r     <= 1'b0;
    end else begin
      if (ready_up)
        v_r <= in_valid && item.enabled;
      if (in_fire) begin
        mode_r  <= mode_nxt;
        fault_r <= fault_nxt;
        hb_r    <= hb_nxt;
        cmd_r   <= cmd_nxt;
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.now_ms <= item.now_ms;
      s1_r.kind   <= kind;
      s1_r.mode   <= mode_nxt;
    end
  end

endmodule

### sv/slpb_div.sv
module slpb_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s1_valid,
  input  slpb_pkg::s1_t s1,
  output logic          ready_up,
  output logic          s3_valid,
  output slpb_pkg::s3_t s3,
  input  logic          ready_dn
);

  logic          s2_v_r, s3_v_r;
  slpb_pkg::s2_t s2_r;
  slpb_pkg::s3_t s3_r;
  logic          s2_ready, s3_ready;

  logic [58:0]   p200, p120;
  logic [60:0]   p300;
  logic [56:0]   p1200;
  logic [32:0]   qm;
  logic [10:0]   phase;
  logic [10:0]   fold;

  assign s3_ready = !s3_v_r || ready_dn;
  assign s2_ready = !s2_v_r || s3_ready;
  assign ready_up = s2_ready;
  assign s3_valid = s3_v_r;
  assign s3       = s3_r;

  // Reciprocal multiplies: quotient parities and the coarse quotient by 1200.
  always_comb begin
    p200  = 59'(s1.now_ms[31:3]) * 59'(slpb_pkg::DIV25_M);
    p120  = 59'(s1.now_ms[31:3]) * 59'(slpb_pkg::DIV15_M);
    p300  = 61'(s1.now_ms[31:2]) * 61'(slpb_pkg::DIV300_M);
    p1200 = 57'(s1.now_ms[31:4]) * 57'(slpb_pkg::DIV1200_M);
  end

  // Remainder mod 1200 and folding into the triangle.
  always_comb begin
    qm    = 33'(s2_r.q1200) * 33'(slpb_pkg::BOOT_PERIOD);
    phase = s2_r.now_lo - qm[10:0];
    fold  = (phase < slpb_pkg::BOOT_HALF) ? phase : (slpb_pkg::BOOT_PERIOD - phase);
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s2_ready)
        s2_v_r <= s1_valid;
      if (s3_ready)
        s3_v_r <= s2_v_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_r.kind   <= s1.kind;
      s2_r.mode   <= s1.mode;
      s2_r.odd200 <= p200[34];
      s2_r.odd120 <= p120[33];
      s2_r.odd300 <= p300[37];
      s2_r.now_lo <= s1.now_ms[10:0];
      s2_r.q1200  <= p1200[56:35];
    end
    if (s3_ready && s2_v_r) begin
      s3_r.kind   <= s2_r.kind;
      s3_r.mode   <= s2_r.mode;
      s3_r.odd200 <= s2_r.odd200;
      s3_r.odd120 <= s2_r.odd120;
      s3_r.odd300 <= s2_r.odd300;
      s3_r.ramp   <= fold[9:0];
    end
  end

endmodule

### sv/slpb_color.sv
module slpb_color (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s3_valid,
  input  slpb_pkg::s3_t s3,
  output logic          ready_up,
  output logic          out_valid,
  output slpb_pkg::rgb_t rgb,
  input  logic          out_ready
);

  logic           v_r;
  slpb_pkg::rgb_t rgb_r, rgb_nxt;
  slpb_pkg::rgb_t base;
  logic [28:0]    breath;
  logic [7:0]     grey;

  assign ready_up  = !v_r || out_ready;
  assign out_valid = v_r;
  assign rgb       = rgb_r;

  // Base color; booting breathes grey.
  always_comb begin
    breath = 29'(s3.ramp) * 29'(slpb_pkg::BREATH_K);
    grey   = breath[27:20];
    case (s3.mode)
      slpb_pkg::MODE_BOOT:   base = '{blue: grey, green: grey, red: grey};
      slpb_pkg::MODE_READY:  base = slpb_pkg::RGB_READY;
      slpb_pkg::MODE_DRIVE:  base = slpb_pkg::RGB_DRIVE;
      default:               base = slpb_pkg::RGB_PAUSED;
    endcase
  end

  // Final color; a blink is lit while its quotient is even.
  always_comb begin
    case (s3.kind)
      slpb_pkg::KIND_STOP:   rgb_nxt = s3.odd200 ? slpb_pkg::RGB_BLACK : slpb_pkg::RGB_RED;
      slpb_pkg::KIND_FAULT:  rgb_nxt = slpb_pkg::RGB_RED;
      slpb_pkg::KIND_REMOTE: rgb_nxt = s3.odd120 ? slpb_pkg::RGB_BLACK : slpb_pkg::RGB_AMBER;
      slpb_pkg::KIND_CMD:    rgb_nxt = s3.odd200 ? slpb_pkg::RGB_BLACK : slpb_pkg::RGB_GREEN;
      slpb_pkg::KIND_LOCAL:  rgb_nxt = s3.odd300 ? slpb_pkg::RGB_BLACK : slpb_pkg::RGB_BLUE;
      slpb_pkg::KIND_HEART:  rgb_nxt = s3.odd200 ? slpb_pkg::RGB_BLACK : slpb_pkg::RGB_YELLOW;
      default:               rgb_nxt = base;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_up) begin
      v_r <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && s3_valid)
      rgb_r <= rgb_nxt;
  end

endmodule

### sv/status_led_priority_blinker_unit.sv
// Status LED priority blinker.
// Input channel: one word per millisecond tick with the time and the status
// levels and event strobes. Result channel: one RGB duty word for each tick
// whose enable bit is set; ticks with enable low only update the stored mode,
// fault latch and window stamps.
// A word accepted at a clock edge is registered there by the priority stage,
// then passes the reciprocal multiply stage, the remainder stage and the
// output register before its result shows on out_tvalid. Throughput is one
// word per clock while out_tready stays high; the stored state is updated in
// the same cycle a word is accepted, so back-to-back words see each other's
// strobes and stamp clears.
// Reset clears the stage valids, sets the base mode to booting, clears the
// fault latch and both stamps.
// When the receiver stalls, each stage holds its word; empty stages still
// fill, so words keep being accepted until the pipeline is full, after which
// in_tready drops until out_tready returns.
module status_led_priority_blinker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] now_ms, [32] enabled, [33] set_base, [35:34] base_mode,
  // [36] raise_error, [37] stop_active, [38] remote_alarm, [39] local_alarm,
  // [40] heartbeat_pulse, [41] command_pulse, [47:42] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [23:0] out_tdata
);

  slpb_pkg::in_item_t item;
  slpb_pkg::s1_t      s1;
  slpb_pkg::s3_t      s3;
  slpb_pkg::rgb_t     rgb;
  logic               s1_valid, s3_valid;
  logic               div_ready, color_ready;

  // Unpack the input word.
  always_comb begin
    item.now_ms          = in_tdata[31:0];
    item.enabled         = in_tdata[32];
    item.set_base        = in_tdata[33];
    item.base_mode       = in_tdata[35:34];
    item.raise_error     = in_tdata[36];
    item.stop_active     = in_tdata[37];
    item.remote_alarm    = in_tdata[38];
    item.local_alarm     = in_tdata[39];
    item.heartbeat_pulse = in_tdata[40];
    item.command_pulse   = in_tdata[41];
  end

  slpb_state u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .item     (item),
    .ready_up (in_tready),
    .s1_valid (s1_valid),
    .s1       (s1),
    .ready_dn (div_ready)
  );

  slpb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1       (s1),
    .ready_up (div_ready),
    .s3_valid (s3_valid),
    .s3       (s3),
    .ready_dn (color_ready)
  );

  slpb_color u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .s3_valid  (s3_valid),
    .s3        (s3),
    .ready_up  (color_ready),
    .out_valid (out_tvalid),
    .rgb       (rgb),
    .out_ready (out_tready)
  );

  assign out_tdata = rgb;

  // An empty output register means the whole pipeline can move.
  a_ready_when_out_empty: assert property (
    @(posedge clk) disable iff (!rst_n) !out_tvalid |-> in_tready
  ) else $error("input stalled while the output register is empty");

  // An enabled stop tick always enters the pipeline as a stop color.
  a_stop_priority: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[32] && in_tdata[37]
      |=> s1_valid && (s1.kind == slpb_pkg::KIND_STOP)
  ) else $error("stop tick lost its priority");

  // A taken result with nothing behind it leaves the output empty.
  a_no_repeat: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !s3_valid |=> !out_tvalid
  ) else $error("result word repeated");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // Blink half periods, window lengths and the breathing period in milliseconds.
  localparam logic [31:0] STOP_BLINK_MS   = 32'd200;
  localparam logic [31:0] NOTE_BLINK_MS   = 32'd200;
  localparam logic [31:0] REMOTE_BLINK_MS = 32'd120;
  localparam logic [31:0] LOCAL_BLINK_MS  = 32'd300;
  localparam logic [31:0] CMD_WINDOW_MS   = 32'd250;
  localparam logic [31:0] HB_WINDOW_MS    = 32'd200;
  localparam logic [31:0] BREATH_MS       = 32'd1200;

  // Colors, kept apart from the package so a wrong constant there shows up.
  localparam slpb_pkg::rgb_t LED_OFF    = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
  localparam slpb_pkg::rgb_t LED_RED    = '{blue: 8'd0,   green: 8'd0,   red: 8'd255};
  localparam slpb_pkg::rgb_t LED_AMBER  = '{blue: 8'd0,   green: 8'd140, red: 8'd255};
  localparam slpb_pkg::rgb_t LED_GREEN  = '{blue: 8'd0,   green: 8'd255, red: 8'd0};
  localparam slpb_pkg::rgb_t LED_BLUE   = '{blue: 8'd255, green: 8'd0,   red: 8'd0};
  localparam slpb_pkg::rgb_t LED_YELLOW = '{blue: 8'd0,   green: 8'd200, red: 8'd255};
  localparam slpb_pkg::rgb_t LED_WHITE  = '{blue: 8'd255, green: 8'd255, red: 8'd255};
  localparam slpb_pkg::rgb_t LED_DIM    = '{blue: 8'd200, green: 8'd200, red: 8'd200};
  localparam slpb_pkg::rgb_t LED_TEAL   = '{blue: 8'd128, green: 8'd128, red: 8'd0};

  localparam int RANDOM_TICKS = 650;
  localparam int STALL_LONG   = 400;
  localparam int IDLE_LIMIT   = 5000;
  localparam int TAIL_CYCLES  = 20;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  // Shadow copy of the blinker state.
  slpb_pkg::mode_t mode_q = slpb_pkg::MODE_BOOT;
  logic            fault_q = 1'b0;
  logic [31:0]     hb_stamp = '0;
  logic [31:0]     cmd_stamp = '0;

  slpb_pkg::in_item_t pending_ticks[$];
  slpb_pkg::rgb_t     led_expected[$];
  slpb_pkg::in_item_t tick_on_bus;
  int          ticks_taken = 0;
  int          ticks_total = 0;
  int          mismatch_count = 0;
  int          tx_wait = 0;
  bit          tx_calm = 1'b0;
  int          rx_wait = 0;
  int          rx_count = 0;
  bit          rx_calm = 1'b0;
  int          idle_cycles = 0;

  status_led_priority_blinker_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic slpb_pkg::in_item_t tick_word(logic [31:0] now, bit en, bit sb,
                                                   slpb_pkg::mode_t bm,
                                                   bit err, bit stop, bit rem, bit loc,
                                                   bit hb, bit cmd);
    slpb_pkg::in_item_t w;
    w.now_ms          = now;
    w.enabled         = en;
    w.set_base        = sb;
    w.base_mode       = bm;
    w.raise_error     = err;
    w.stop_active     = stop;
    w.remote_alarm    = rem;
    w.local_alarm     = loc;
    w.heartbeat_pulse = hb;
    w.command_pulse   = cmd;
    return w;
  endfunction

  // On in the even half periods, dark in the odd ones.
  function automatic slpb_pkg::rgb_t blink(logic [31:0] now, logic [31:0] half,
                                           slpb_pkg::rgb_t lit);
    return ((now / half) % 2 == 0) ? lit : LED_OFF;
  endfunction

  // Color of the stored mode; booting breathes grey over a triangle.
  function automatic slpb_pkg::rgb_t base_color(logic [31:0] now);
    logic [31:0] phase;
    logic [31:0] level;
    slpb_pkg::rgb_t c;
    case (mode_q)
      slpb_pkg::MODE_BOOT: begin
        phase = now % BREATH_MS;
        if (phase >= BREATH_MS / 2) phase = BREATH_MS - phase;
        level = (phase * 32'd17) / 32'd40;
        c = '{blue: level[7:0], green: level[7:0], red: level[7:0]};
      end
      slpb_pkg::MODE_READY: c = LED_WHITE;
      slpb_pkg::MODE_DRIVE: c = LED_DIM;
      default:              c = LED_TEAL;
    endcase
    return c;
  endfunction

  // Apply one tick's strobes and queue the color it should show, if enabled.
  function automatic void color_for_tick(slpb_pkg::in_item_t t);
    slpb_pkg::rgb_t c;
    if (t.set_base) begin
      mode_q = slpb_pkg::mode_t'(t.base_mode);
      if (t.base_mode <= slpb_pkg::MODE_READY) fault_q = 1'b0;
    end
    if (t.raise_error) fault_q = 1'b1;
    if (t.heartbeat_pulse) hb_stamp = t.now_ms;
    if (t.command_pulse) cmd_stamp = t.now_ms;
    if (!t.enabled) return;

    if (t.stop_active) begin
      c = blink(t.now_ms, STOP_BLINK_MS, LED_RED);
    end else if (fault_q) begin
      c = LED_RED;
    end else if (t.remote_alarm) begin
      c = blink(t.now_ms, REMOTE_BLINK_MS, LED_AMBER);
    end else if (cmd_stamp != 0 && (t.now_ms - cmd_stamp) < CMD_WINDOW_MS) begin
      c = blink(t.now_ms, NOTE_BLINK_MS, LED_GREEN);
    end else if (cmd_stamp != 0) begin
      cmd_stamp = '0;
      c = base_color(t.now_ms);
    end else if (t.local_alarm) begin
      c = blink(t.now_ms, LOCAL_BLINK_MS, LED_BLUE);
    end else if (hb_stamp != 0 && (t.now_ms - hb_stamp) < HB_WINDOW_MS) begin
      c = (mode_q == slpb_pkg::MODE_DRIVE) ? blink(t.now_ms, NOTE_BLINK_MS, LED_YELLOW)
                                           : base_color(t.now_ms);
    end else begin
      hb_stamp = '0;
      c = base_color(t.now_ms);
    end
    led_expected.push_back(c);
  endfunction

  // Sender: predict on each accepted word, then offer the next one after its gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      tx_wait   <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        color_for_tick(tick_on_bus);
        ticks_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_wait != 0) begin
          tx_wait   <= tx_wait - 1;
          in_tvalid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          tick_on_bus = pending_ticks.pop_front();
          in_tdata  <= {6'b0, tick_on_bus.command_pulse, tick_on_bus.heartbeat_pulse,
                        tick_on_bus.local_alarm, tick_on_bus.remote_alarm,
                        tick_on_bus.stop_active, tick_on_bus.raise_error,
                        tick_on_bus.base_mode, tick_on_bus.set_base,
                        tick_on_bus.enabled, tick_on_bus.now_ms};
          in_tvalid <= 1'b1;
          if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
          tx_wait <= tx_calm ? 0 : $urandom_range(0, 19);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall after each word, and two long hold-offs to back up the pipe.
  always @(posedge clk) begin : receiver
    int w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait    <= 0;
    end else if (rx_wait != 0) begin
      out_tready <= 1'b0;
      rx_wait    <= rx_wait - 1;
    end else if (out_tvalid && out_tready) begin
      rx_count++;
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
      w = rx_calm ? 0 : $urandom_range(0, 19);
      if (rx_count == 60 || rx_count == 450) w = STALL_LONG;
      rx_wait    <= w;
      out_tready <= (w == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each accepted color word with the oldest prediction.
  always @(posedge clk) begin : scoreboard
    slpb_pkg::rgb_t seen;
    slpb_pkg::rgb_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata;
      if (led_expected.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, out_tdata);
        mismatch_count++;
      end else begin
        want = led_expected.pop_front();
        if (seen.red != want.red) begin
          $display("%0t: red expected %0d actual %0d", $time, want.red, seen.red);
          mismatch_count++;
        end
        if (seen.green != want.green) begin
          $display("%0t: green expected %0d actual %0d", $time, want.green, seen.green);
          mismatch_count++;
        end
        if (seen.blue != want.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time, want.blue, seen.blue);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout with %0d ticks accepted", $time, ticks_taken);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int          i;
    int          r;
    logic [31:0] t;

    // Stamps taken at time zero open no window; breathing extremes.
    pending_ticks.push_back(tick_word(32'd0,    1, 0, slpb_pkg::MODE_BOOT, 0, 0, 0, 0, 1, 1));
    pending_ticks.push_back(tick_word(32'd599,  1, 0, slpb_pkg::MODE_BOOT, 0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(tick_word(32'd600,  1, 0, slpb_pkg::MODE_BOOT, 0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(tick_word(32'd1199, 1, 0, slpb_pkg::MODE_BOOT, 0, 0, 0, 0, 0, 0));
    // Fault set in the same tick as a clearing mode load, kept by drive mode,
    // then cleared by ready on a disabled tick.
    pending_ticks.push_back(tick_word(32'd1250, 1, 1, slpb_pkg::MODE_READY, 1, 0, 0, 0, 0, 0));
    pending_ticks.push_back(tick_word(32'd1260, 1, 1, slpb_pkg::MODE_DRIVE, 0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(tick_word(32'd1270, 0, 1, slpb_pkg::MODE_READY, 0, 0, 0, 0, 0, 0));
    // Stop and remote alarm on both blink phases.
    pending_ticks.push_back(tick_word(32'd1280, 1, 0, slpb_pkg::MODE_READY, 0, 1, 0, 0, 0, 0));
    pending_ticks.push_back(tick_word(32'd1400, 1, 0, slpb_pkg::MODE_READY, 0, 1, 0, 0, 0, 0));
    pending_ticks.push_back(tick_word(32'd1440, 1, 0, slpb_pkg::MODE_READY, 0, 0, 1, 0, 0, 0));
    pending_ticks.push_back(tick_word(32'd1560, 1, 0, slpb_pkg::MODE_READY, 0, 0, 1, 0, 0, 0));
    // Command window over a local alarm; expiry hidden by stop, then shown as base.
    pending_ticks.push_back(tick_word(32'd2000, 1, 0, slpb_pkg::MODE_READY, 0, 0, 0, 1, 0, 1));
    pending_ticks.push_back(tick_word(32'd2200, 1, 0, slpb_pkg::MODE_READY, 0, 0, 0, 1, 0, 0));
    pending_ticks.push_back(tick_word(32'd2300, 1, 0, slpb_pkg::MODE_READY, 0, 1, 0, 0, 0, 0));
    pending_ticks.push_back(tick_word(32'd2301, 1, 0, slpb_pkg::MODE_READY, 0, 0, 0, 1, 1, 0));
    pending_ticks.push_back(tick_word(32'd2400, 1, 0, slpb_pkg::MODE_READY, 0, 0, 0, 1, 0, 0));
    // Heartbeat in drive mode, its last running tick, a disabled expiry, the clear.
    pending_ticks.push_back(tick_word(32'd2410, 1, 1, slpb_pkg::MODE_DRIVE, 0, 0, 0, 0, 1, 0));
    pending_ticks.push_back(tick_word(32'd2609, 1, 0, slpb_pkg::MODE_DRIVE, 0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(tick_word(32'd2610, 0, 0, slpb_pkg::MODE_DRIVE, 0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(tick_word(32'd2611, 1, 0, slpb_pkg::MODE_DRIVE, 0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(tick_word(32'd2700, 1, 1, slpb_pkg::MODE_PAUSED, 0, 0, 0, 0, 0, 0));
    // Command window across the time wrap.
    pending_ticks.push_back(tick_word(32'hFFFF_FF80, 1, 0, slpb_pkg::MODE_PAUSED,
                                      0, 0, 0, 0, 0, 1));
    pending_ticks.push_back(tick_word(32'h0000_0010, 1, 1, slpb_pkg::MODE_BOOT,
                                      0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(tick_word(32'hFFFF_FFFF, 1, 0, slpb_pkg::MODE_BOOT,
                                      1, 1, 1, 1, 1, 1));
    pending_ticks.push_back(tick_word(32'h5A5A_5A5A, 1, 1, slpb_pkg::MODE_BOOT,
                                      0, 0, 0, 0, 0, 0));

    // Random part: a running clock with occasional jumps, rare strobes.
    t = 32'd3000;
    for (i = 0; i < RANDOM_TICKS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) t = $urandom();
      else if (r < 7) t = 32'hFFFF_FFFF - $urandom_range(0, 700);
      else if (r < 12) t = t + $urandom_range(200, 1500);
      else t = t + $urandom_range(0, 90);
      pending_ticks.push_back(tick_word(t,
        $urandom_range(0, 7) != 0, $urandom_range(0, 11) == 0,
        slpb_pkg::mode_t'($urandom_range(0, 3)), $urandom_range(0, 39) == 0,
        $urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0,
        $urandom_range(0, 5) == 0, $urandom_range(0, 7) == 0,
        $urandom_range(0, 9) == 0));
    end
    ticks_total = pending_ticks.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (ticks_taken != ticks_total || led_expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (led_expected.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, led_expected.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
